[design/ptt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants of the pan/tilt point tracker.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int CW = 38;
  localparam int ZW = 26;
  localparam int PW = 21;
  localparam int IDXW = 5;
  localparam int ATAN_N = 24;

  localparam logic signed [ZW-1:0] QUARTER_FINE = 26'sd5898240;
  localparam logic signed [PW-1:0] FULL_TURN = 21'sd92160;
  localparam logic signed [PW-1:0] QUARTER_TURN = 21'sd23040;
  localparam logic signed [17:0] TILT_MARGIN = 18'sd26;
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

  localparam logic [3:0] REG_TX = 4'd0;
  localparam logic [3:0] REG_TY = 4'd1;
  localparam logic [3:0] REG_TH = 4'd2;
  localparam logic [3:0] REG_EN = 4'd3;
  localparam logic [3:0] REG_PMIN = 4'd4;
  localparam logic [3:0] REG_PMAX = 4'd5;
  localparam logic [3:0] REG_TMIN = 4'd6;
  localparam logic [3:0] REG_TMAX = 4'd7;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  function automatic logic signed [ZW-1:0] atan_fine(input logic [IDXW-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0: r = 26'sd2949120;
      5'd1: r = 26'sd1740967;
      5'd2: r = 26'sd919879;
      5'd3: r = 26'sd466945;
      5'd4: r = 26'sd234379;
      5'd5: r = 26'sd117305;
      5'd6: r = 26'sd58666;
      5'd7: r = 26'sd29335;
      5'd8: r = 26'sd14668;
      5'd9: r = 26'sd7334;
      5'd10: r = 26'sd3667;
      5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;
      5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;
      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;
      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

endpackage

[design/ptt_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_cordic
// Iterative CORDIC vectoring unit, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ptt_cordic #(
  parameter int STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [ptt_pkg::CW-1:0] x_in,
  input  logic signed [ptt_pkg::CW-1:0] y_in,
  output ptt_pkg::cordic_stat_t         stat,
  output logic signed [ptt_pkg::CW-1:0] x_out,
  output logic signed [ptt_pkg::ZW-1:0] z_out
);

  localparam logic [ptt_pkg::IDXW-1:0] LAST = ptt_pkg::IDXW'(STEPS - 1);

  logic signed [ptt_pkg::CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ptt_pkg::ZW-1:0] z_r, z_nxt;
  logic [ptt_pkg::IDXW-1:0] cnt_r, cnt_nxt;
  logic run_r, run_nxt, done_r, done_nxt;
  logic signed [ptt_pkg::CW-1:0] xs, ys;

  always_comb begin
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = '0;
      run_nxt = 1'b1;
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_nxt = y_in;
          y_nxt = -x_in;
          z_nxt = ptt_pkg::QUARTER_FINE;
        end else begin
          x_nxt = -y_in;
          y_nxt = x_in;
          z_nxt = -ptt_pkg::QUARTER_FINE;
        end
      end else begin
        x_nxt = x_in;
        y_nxt = y_in;
        z_nxt = '0;
      end
    end else if (run_r) begin
      if (y_r >= 0) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + ptt_pkg::atan_fine(cnt_r);
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - ptt_pkg::atan_fine(cnt_r);
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign x_out = x_r;
  assign z_out = z_r;

endmodule

[design/pan_tilt_point_tracker_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pan_tilt_point_tracker_core
// Turns robot pose reports into pan/tilt commands aimed at a target point.
// ----------------------------------------------------------------------------
// A pose report is a transfer on the in_ channel. Registers are written on
// the cfg_ channel, which is always ready. With tracking off, or when no more
// than GATE_INTERVAL_MS has passed since the previous report taken with
// tracking on, a report yields no result and the block is ready again in the
// next cycle. Otherwise one pan/tilt result is placed on the out_ channel
// after the shared CORDIC unit has run bearing and then elevation and the
// 360-degree pan wrap steps are done. A report at the target itself skips
// the CORDIC unit and goes straight to the wrap steps. in_ready is high only
// while the sequencer is idle, so the next report can be taken from the
// cycle after the previous result enters the output register.
// A finished result waits in the output register while the receiver stalls;
// the next report is taken meanwhile, and its result waits until the
// previous one has been transferred. Reset restores the register defaults,
// clears the last report time and empties the output register.
// ----------------------------------------------------------------------------
module pan_tilt_point_tracker_core #(
  parameter int GATE_INTERVAL_MS = 500,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_robot_x,
  input  logic signed [23:0] in_robot_y,
  input  logic signed [17:0] in_robot_heading,
  input  logic [31:0]        in_time_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [18:0] out_pan_command,
  output logic signed [15:0] out_tilt_command,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BEAR = 3'd1;
  localparam logic [2:0] S_MUL = 3'd2;
  localparam logic [2:0] S_ELEV = 3'd3;
  localparam logic [2:0] S_WRAPHI = 3'd4;
  localparam logic [2:0] S_WRAPLO = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam int CW = ptt_pkg::CW;
  localparam int PW = ptt_pkg::PW;

  logic signed [23:0] tx_r, ty_r;
  logic signed [20:0] th_r;
  logic en_r;
  logic signed [18:0] pmin_r, pmax_r;
  logic signed [15:0] tmin_r, tmax_r;
  logic [31:0] last_r;

  logic [2:0] st_r, st_nxt;
  logic signed [CW-1:0] dx_r, dy_r;
  logic signed [17:0] hd_r;
  logic signed [CW-1:0] dist_r;
  logic signed [PW-1:0] pan_r, pan_nxt;
  logic signed [17:0] tilt_r, tilt_nxt;
  logic out_valid_r;
  logic signed [18:0] pan_o_r;
  logic signed [15:0] tilt_o_r;

  logic accept, go, start;
  logic [31:0] elapsed;
  logic signed [24:0] dxn, dyn;
  logic signed [CW-1:0] cx, cy;
  ptt_pkg::cordic_stat_t cstat;
  logic signed [CW-1:0] cx_out;
  logic signed [ptt_pkg::ZW-1:0] cz_out;
  logic signed [ptt_pkg::ZW-1:0] zr;
  logic signed [21:0] ah;
  logic [50:0] prod;
  logic signed [17:0] er, tl;
  logic load_out;

  assign cfg_ready = 1'b1;
  assign in_ready = (st_r == S_IDLE);
  assign accept = in_valid && in_ready;
  assign elapsed = in_time_ms - last_r;
  assign go = accept && en_r && (elapsed > 32'(GATE_INTERVAL_MS));
  assign dxn = 25'(tx_r) - 25'(in_robot_x);
  assign dyn = 25'(ty_r) - 25'(in_robot_y);
  assign ah = th_r[20] ? -22'(th_r) : 22'(th_r);
  assign prod = cx_out[34:0] * ptt_pkg::INV_GAIN_Q16;
  assign load_out = (st_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    start = 1'b0;
    cx = dy_r;
    cy = dx_r;
    if (st_r == S_IDLE && go && (dxn != 0 || dyn != 0)) begin
      start = 1'b1;
      cx = CW'(dyn) <<< 8;
      cy = CW'(dxn) <<< 8;
    end else if (st_r == S_MUL) begin
      start = 1'b1;
      cx = dist_r;
      cy = CW'(ah) <<< 8;
    end
  end

  ptt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(start), .x_in(cx), .y_in(cy),
    .stat(cstat), .x_out(cx_out), .z_out(cz_out)
  );

  always_comb begin
    zr = (cz_out + ptt_pkg::ZW'(128)) >>> 8;
    er = 18'((cz_out + ptt_pkg::ZW'(128)) >>> 8);
    tl = tilt_r;
    if (tl < 18'(tmin_r)) tl = 18'(tmin_r) + ptt_pkg::TILT_MARGIN;
    if (tl > 18'(tmax_r)) tl = 18'(tmax_r) - ptt_pkg::TILT_MARGIN;
  end

  always_comb begin
    st_nxt = st_r;
    pan_nxt = pan_r;
    tilt_nxt = tilt_r;
    case (st_r)
      S_IDLE: begin
        if (go) begin
          if (dxn == 0 && dyn == 0) begin
            pan_nxt = -ptt_pkg::QUARTER_TURN;
            tilt_nxt = '0;
            st_nxt = S_WRAPHI;
          end else begin
            st_nxt = S_BEAR;
          end
        end
      end
      S_BEAR: begin
        if (cstat.done) begin
          pan_nxt = PW'(hd_r) - ptt_pkg::QUARTER_TURN - PW'(zr);
          st_nxt = S_MUL;
        end
      end
      S_MUL: st_nxt = S_ELEV;
      S_ELEV: begin
        if (cstat.done) begin
          tilt_nxt = th_r[20] ? -er : er;
          st_nxt = S_WRAPHI;
        end
      end
      S_WRAPHI: begin
        if (pan_r >= PW'(pmax_r)) pan_nxt = pan_r - ptt_pkg::FULL_TURN;
        else st_nxt = S_WRAPLO;
      end
      S_WRAPLO: begin
        if (pan_r < PW'(pmin_r)) pan_nxt = pan_r + ptt_pkg::FULL_TURN;
        else st_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid_r <= 1'b0;
      last_r <= '0;
      tx_r <= '0;
      ty_r <= '0;
      th_r <= '0;
      en_r <= 1'b0;
      pmin_r <= -19'sd40960;
      pmax_r <= 19'sd40960;
      tmin_r <= -16'sd11520;
      tmax_r <= 16'sd7680;
    end else begin
      st_r <= st_nxt;
      if (accept && en_r) last_r <= in_time_ms;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          ptt_pkg::REG_TX: tx_r <= cfg_data;
          ptt_pkg::REG_TY: ty_r <= cfg_data;
          ptt_pkg::REG_TH: th_r <= cfg_data[20:0];
          ptt_pkg::REG_EN: en_r <= cfg_data[0];
          ptt_pkg::REG_PMIN: pmin_r <= cfg_data[18:0];
          ptt_pkg::REG_PMAX: pmax_r <= cfg_data[18:0];
          ptt_pkg::REG_TMIN: tmin_r <= cfg_data[15:0];
          ptt_pkg::REG_TMAX: tmax_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
    if (accept) begin
      dx_r <= CW'(dxn);
      dy_r <= CW'(dyn);
      hd_r <= in_robot_heading;
    end
    if (st_r == S_BEAR && cstat.done) dist_r <= CW'(prod[50:16]);
    pan_r <= pan_nxt;
    tilt_r <= tilt_nxt;
    if (load_out) begin
      pan_o_r <= pan_r[18:0];
      tilt_o_r <= tl[15:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_pan_command = pan_o_r;
  assign out_tilt_command = tilt_o_r;

endmodule

[tb/pan_tilt_point_tracker_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pan_tilt_point_tracker_core_tb
// Self-checking bench for the pan/tilt point tracker. Pose reports are sent
// with random gaps, and commands are received with random stalls. Each
// command is checked against a bit-exact fixed-point CORDIC predictor over
// several register settings, including inverted windows and the range limits.
// ----------------------------------------------------------------------------
module pan_tilt_point_tracker_core_tb;

  localparam int GATE_MS = 500;
  localparam int STEPS = 16;

  typedef struct packed {
    logic signed [18:0] pan;
    logic signed [15:0] tilt;
  } aim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] in_robot_x = '0;
  logic signed [23:0] in_robot_y = '0;
  logic signed [17:0] in_robot_heading = '0;
  logic [31:0] in_time_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [18:0] out_pan_command;
  logic signed [15:0] out_tilt_command;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  pan_tilt_point_tracker_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  aim_t aim_q[$];
  int errors = 0;
  bit calm = 1'b0;
  logic [31:0] now_ms = 32'd0;

  longint tgt_x = 0, tgt_y = 0, tgt_h = 0, p_min = -40960, p_max = 40960;
  longint t_min = -11520, t_max = 7680;
  bit track_on = 1'b0;
  logic [31:0] last_seen = 32'd0;

  longint atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117305,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1, 0};

  function automatic longint vector_angle(longint x, longint y, output longint mag);
    longint z, t, xs, ys;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 5898240;
      end else begin
        t = x; x = -y; y = t; z = -5898240;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += atan_tab[i];
      end else begin
        x = x - ys; y = y + xs; z -= atan_tab[i];
      end
    end
    mag = x;
    return z;
  endfunction

  task automatic predict_aim(longint rx, longint ry, longint hd, logic [31:0] t);
    longint dx, dy, pan, tilt, mag, dist_mm, z, e, ah, k, dummy;
    logic [31:0] elapsed;
    aim_t a;
    if (!track_on) return;
    elapsed = t - last_seen;
    last_seen = t;
    if (elapsed <= GATE_MS) return;
    dx = tgt_x - rx;
    dy = tgt_y - ry;
    if (dx == 0 && dy == 0) begin
      pan = -23040;
      tilt = 0;
    end else begin
      z = vector_angle(dy * 256, dx * 256, mag);
      dist_mm = (mag * 39797) >>> 16;
      ah = (tgt_h < 0) ? -tgt_h : tgt_h;
      e = vector_angle(dist_mm, ah * 256, dummy);
      tilt = (e + 128) >>> 8;
      if (tgt_h < 0) tilt = -tilt;
      pan = hd - 23040 - ((z + 128) >>> 8);
    end
    if (pan >= p_max) begin
      k = (pan - p_max) / 92160 + 1;
      pan -= k * 92160;
    end
    if (pan < p_min) begin
      k = (p_min - 1 - pan) / 92160 + 1;
      pan += k * 92160;
    end
    if (tilt < t_min) tilt = t_min + 26;
    if (tilt > t_max) tilt = t_max - 26;
    a.pan = pan[18:0];
    a.tilt = tilt[15:0];
    aim_q.push_back(a);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 27);
  endfunction

  always @(posedge clk) begin
    aim_t w;
    if (rst_n && out_valid && out_ready) begin
      if (aim_q.size() == 0) begin
        report_mismatch("unexpected command", out_pan_command, 0);
      end else begin
        w = aim_q.pop_front();
        if (out_pan_command !== w.pan) report_mismatch("pan", out_pan_command, w.pan);
        if (out_tilt_command !== w.tilt) report_mismatch("tilt", out_tilt_command, w.tilt);
      end
    end
    if (rst_n) out_ready <= !idle_now();
  end

  task automatic write_reg(logic [3:0] idx, longint v);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[23:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ptt_pkg::REG_TX: tgt_x = v;
      ptt_pkg::REG_TY: tgt_y = v;
      ptt_pkg::REG_TH: tgt_h = v;
      ptt_pkg::REG_EN: track_on = v[0];
      ptt_pkg::REG_PMIN: p_min = v;
      ptt_pkg::REG_PMAX: p_max = v;
      ptt_pkg::REG_TMIN: t_min = v;
      default: t_max = v;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (aim_q.size() != 0) @(posedge clk);
    repeat (2 * STEPS + 40) @(posedge clk);
  endtask

  task automatic send_pose(longint rx, longint ry, longint hd, logic [31:0] t);
    cfg_valid <= 1'b0;
    if (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (idle_now()) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_robot_x <= rx[23:0];
    in_robot_y <= ry[23:0];
    in_robot_heading <= hd[17:0];
    in_time_ms <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_aim(rx, ry, hd, t);
  endtask

  function automatic longint rand_s(int w);
    logic [31:0] r;
    r = $urandom();
    return longint'($signed(r << (32 - w))) >>> (32 - w);
  endfunction

  function automatic longint rand_heading();
    return longint'($urandom_range(184320)) - 92160;
  endfunction

  task automatic send_gated();
    now_ms = now_ms + GATE_MS + 1 + $urandom_range(3000);
    send_pose(rand_s(24), rand_s(24), rand_heading(), now_ms);
  endtask

  task automatic test_directed();
    write_reg(ptt_pkg::REG_EN, 0);
    send_pose(0, 0, 0, 32'd9000);
    write_reg(ptt_pkg::REG_EN, 1);
    send_pose(5, 5, 0, 32'd400);
    send_pose(0, 0, 0, 32'd900);
    send_pose(0, 0, 92160, 32'd1401);
    send_pose(0, 0, -92160, 32'd1901);
    write_reg(ptt_pkg::REG_TX, 8388607);
    write_reg(ptt_pkg::REG_TY, -8388608);
    write_reg(ptt_pkg::REG_TH, -1048576);
    send_pose(-8388608, 8388607, 92160, 32'd5000);
    send_pose(8388607, -8388608, -92160, 32'd10000);
    send_pose(0, 0, 0, 32'd10200);
    send_pose(0, 0, 0, 32'hFFFF_FF00);
    send_pose(1, 0, 0, 32'd2000);
    send_pose(0, -1, 1000, 32'd2500);
    send_pose(-1000, 1000, 0, 32'd3001);
    settle();
    write_reg(ptt_pkg::REG_TH, 1048575);
    write_reg(ptt_pkg::REG_TX, -8388608);
    write_reg(ptt_pkg::REG_TY, 8388607);
    send_pose(8388607, -8388608, 0, 32'd5000);
    send_pose(-8388608, 8388600, 0, 32'd6000);
    now_ms = 32'd6000;
    settle();
  endtask

  task automatic test_windows();
    longint pm[5] = '{-184320, 184320, 0, 30000, -100};
    longint px[5] = '{184320, -184320, 1, -30000, 100};
    longint tm[5] = '{-23040, 23040, 0, 5000, -26};
    longint tx[5] = '{23040, -23040, 0, -5000, 26};
    for (int s = 0; s < 5; s++) begin
      write_reg(ptt_pkg::REG_PMIN, pm[s]);
      write_reg(ptt_pkg::REG_PMAX, px[s]);
      write_reg(ptt_pkg::REG_TMIN, tm[s]);
      write_reg(ptt_pkg::REG_TMAX, tx[s]);
      write_reg(ptt_pkg::REG_TX, rand_s(12));
      write_reg(ptt_pkg::REG_TY, rand_s(12));
      write_reg(ptt_pkg::REG_TH, rand_s(21));
      repeat (20) begin
        now_ms = now_ms + GATE_MS + 1 + $urandom_range(2000);
        send_pose(rand_s(12), rand_s(12), rand_heading(), now_ms);
      end
      settle();
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(ptt_pkg::REG_PMIN, longint'($urandom_range(368640)) - 184320);
      write_reg(ptt_pkg::REG_PMAX, longint'($urandom_range(368640)) - 184320);
      write_reg(ptt_pkg::REG_TMIN, longint'($urandom_range(46080)) - 23040);
      write_reg(ptt_pkg::REG_TMAX, longint'($urandom_range(46080)) - 23040);
      write_reg(ptt_pkg::REG_TX, rand_s(24));
      write_reg(ptt_pkg::REG_TY, rand_s(24));
      write_reg(ptt_pkg::REG_TH, (ph % 2) ? rand_s(21) : rand_s(12));
      write_reg(ptt_pkg::REG_EN, (ph == 3) ? 0 : 1);
      calm = (ph == 5);
      repeat (90) begin
        if ($urandom_range(99) < 80) begin
          send_gated();
        end else begin
          now_ms = now_ms + $urandom_range(600);
          send_pose(rand_s(24), rand_s(24), rand_heading(),
                    ($urandom_range(9) == 0) ? $urandom() : now_ms);
        end
      end
      calm = 1'b0;
      settle();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_windows();
    test_random();
    settle();
    if (errors == 0 && aim_q.size() == 0) begin
      $display("tb: success");
    end else begin
      if (aim_q.size() != 0) report_mismatch("missing commands", aim_q.size(), 0);
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

[pan_tilt_point_tracker_core.f]
design/ptt_pkg.sv
design/ptt_cordic.sv
design/pan_tilt_point_tracker_core.sv
tb/pan_tilt_point_tracker_core_tb.sv
